FILE: rtl/core/qre_pkg.sv
// ----------------------------------------------------------------------------
// qre_pkg: shared types, constants and microcode for the residue enumerator
// Holds the control word layout, the sequencer program, and the structs that
// pass control and status between the sequencer, datapath and top level.
// ----------------------------------------------------------------------------
package qre_pkg;

   localparam int FIELD_WIDTH   = 16;
   localparam int MOD_WIDTH_DEF = 16;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int K_W           = 4;
   localparam int PC_W          = 6;
   localparam int RF_DEPTH      = 9;
   localparam int RF_IDX_W      = 4;

   localparam logic OPC_START   = 1'b0;

   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_COEF_B  = 1'b1;

   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 16'd2;

   localparam logic [K_W-1:0] K_THREE   = 4'd3;
   localparam logic [K_W-1:0] K_SIX     = 4'd6;
   localparam logic [K_W-1:0] K_EIGHT   = 4'd8;
   localparam logic [K_W-1:0] K_TEN     = 4'd10;
   localparam logic [K_W-1:0] K_FIFTEEN = 4'd15;

   typedef enum logic [2:0] {
      OP_JUMP,
      OP_INCA,
      OP_MUL,
      OP_ADD,
      OP_SUB,
      OP_EMIT
   } uop_type;

   typedef enum logic [1:0] {
      CD_START,
      CD_DONE,
      CD_EXHAUST
   } cond_type;

   typedef enum logic [1:0] {
      XS_RF,
      XS_ONE,
      XS_A
   } xsrc_type;

   typedef enum logic [2:0] {
      YS_RF,
      YS_A,
      YS_CFGB,
      YS_CIN,
      YS_K
   } ysrc_type;

   // The first RF_DEPTH entries live in the register file; the three
   // residues are separate registers read by the result path.
   typedef enum logic [RF_IDX_W-1:0] {
      RF_B,
      RF_C,
      RF_SC,
      RF_A2,
      RF_A3,
      RF_A4,
      RF_A5,
      RF_T0,
      RF_T1,
      RF_R3,
      RF_R4,
      RF_R5
   } rf_idx_type;

   typedef enum logic [1:0] {
      EK_RESULT,
      EK_START,
      EK_EXH
   } emit_type;

   typedef struct packed {
      uop_type           op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
      xsrc_type          xs;
      rf_idx_type        rx;
      ysrc_type          ys;
      rf_idx_type        ry;
      logic [K_W-1:0]    kval;
      logic              short_mul;
      rf_idx_type        dst;
      emit_type          ek;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      exec;
      logic      mul_start;
      logic      mul_wb;
   } ctl_type;

   typedef struct packed {
      logic start_op;
      logic done;
      logic exhaust;
      logic mul_done;
   } flags_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] residue_three;
      logic [FIELD_WIDTH-1:0] residue_four;
      logic [FIELD_WIDTH-1:0] residue_five;
      logic [FIELD_WIDTH-1:0] counter_value;
      logic                   exhausted;
   } rsp_type;

   localparam logic [PC_W-1:0] PC_START = PC_W'(31);
   localparam logic [PC_W-1:0] PC_EXH   = PC_W'(33);

   function automatic ucode_type u_word(uop_type op);
      ucode_type w;
      w.op        = op;
      w.cond      = CD_START;
      w.target    = '0;
      w.xs        = XS_RF;
      w.rx        = RF_B;
      w.ys        = YS_RF;
      w.ry        = RF_B;
      w.kval      = '0;
      w.short_mul = 1'b0;
      w.dst       = RF_T0;
      w.ek        = EK_EXH;
      return w;
   endfunction

   function automatic ucode_type u_jmp(cond_type cond, logic [PC_W-1:0] target);
      ucode_type w;
      w        = u_word(OP_JUMP);
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   function automatic ucode_type u_mul(xsrc_type xs, rf_idx_type rx, ysrc_type ys,
                                       rf_idx_type ry, logic [K_W-1:0] k,
                                       rf_idx_type dst);
      ucode_type w;
      w           = u_word(OP_MUL);
      w.xs        = xs;
      w.rx        = rx;
      w.ys        = ys;
      w.ry        = ry;
      w.kval      = k;
      w.short_mul = (ys == YS_K);
      w.dst       = dst;
      return w;
   endfunction

   function automatic ucode_type u_alu(uop_type op, rf_idx_type rx, rf_idx_type ry,
                                       rf_idx_type dst);
      ucode_type w;
      w     = u_word(op);
      w.rx  = rx;
      w.ry  = ry;
      w.dst = dst;
      return w;
   endfunction

   function automatic ucode_type u_emit(emit_type ek);
      ucode_type w;
      w    = u_word(OP_EMIT);
      w.ek = ek;
      return w;
   endfunction

   // Sequencer program. An advance computes powers of a, then the three
   // residues term by term; start reduces c; both exhaustion cases share
   // one final step.
   function automatic ucode_type ucode_rom(logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_W'(0):  w = u_jmp(CD_START, PC_START);
         PC_W'(1):  w = u_jmp(CD_DONE, PC_EXH);
         PC_W'(2):  w = u_word(OP_INCA);
         PC_W'(3):  w = u_jmp(CD_EXHAUST, PC_EXH);
         PC_W'(4):  w = u_mul(XS_ONE, RF_B,  YS_CFGB, RF_B,  '0, RF_B);
         PC_W'(5):  w = u_mul(XS_ONE, RF_B,  YS_RF,   RF_SC, '0, RF_C);
         PC_W'(6):  w = u_mul(XS_A,   RF_B,  YS_A,    RF_B,  '0, RF_A2);
         PC_W'(7):  w = u_mul(XS_RF,  RF_A2, YS_A,    RF_B,  '0, RF_A3);
         PC_W'(8):  w = u_mul(XS_RF,  RF_A2, YS_RF,   RF_A2, '0, RF_A4);
         PC_W'(9):  w = u_mul(XS_RF,  RF_A4, YS_A,    RF_B,  '0, RF_A5);
         PC_W'(10): w = u_mul(XS_RF,  RF_A3, YS_K,    RF_B,  K_TEN, RF_T0);
         PC_W'(11): w = u_mul(XS_RF,  RF_C,  YS_K,    RF_B,  K_THREE, RF_T1);
         PC_W'(12): w = u_mul(XS_RF,  RF_T1, YS_A,    RF_B,  '0, RF_T1);
         PC_W'(13): w = u_alu(OP_ADD, RF_T0, RF_T1, RF_T0);
         PC_W'(14): w = u_mul(XS_RF,  RF_B,  YS_K,    RF_B,  K_SIX, RF_T1);
         PC_W'(15): w = u_mul(XS_RF,  RF_T1, YS_RF,   RF_A2, '0, RF_T1);
         PC_W'(16): w = u_alu(OP_SUB, RF_T0, RF_T1, RF_R3);
         PC_W'(17): w = u_mul(XS_RF,  RF_A4, YS_K,    RF_B,  K_FIFTEEN, RF_T0);
         PC_W'(18): w = u_mul(XS_RF,  RF_C,  YS_K,    RF_B,  K_THREE, RF_T1);
         PC_W'(19): w = u_mul(XS_RF,  RF_T1, YS_RF,   RF_A2, '0, RF_T1);
         PC_W'(20): w = u_alu(OP_ADD, RF_T0, RF_T1, RF_T0);
         PC_W'(21): w = u_mul(XS_RF,  RF_B,  YS_K,    RF_B,  K_EIGHT, RF_T1);
         PC_W'(22): w = u_mul(XS_RF,  RF_T1, YS_RF,   RF_A3, '0, RF_T1);
         PC_W'(23): w = u_alu(OP_SUB, RF_T0, RF_T1, RF_R4);
         PC_W'(24): w = u_mul(XS_RF,  RF_A5, YS_K,    RF_B,  K_SIX, RF_T0);
         PC_W'(25): w = u_mul(XS_RF,  RF_C,  YS_RF,   RF_A3, '0, RF_T1);
         PC_W'(26): w = u_alu(OP_ADD, RF_T0, RF_T1, RF_T0);
         PC_W'(27): w = u_mul(XS_RF,  RF_B,  YS_K,    RF_B,  K_THREE, RF_T1);
         PC_W'(28): w = u_mul(XS_RF,  RF_T1, YS_RF,   RF_A4, '0, RF_T1);
         PC_W'(29): w = u_alu(OP_SUB, RF_T0, RF_T1, RF_R5);
         PC_W'(30): w = u_emit(EK_RESULT);
         PC_W'(31): w = u_mul(XS_ONE, RF_B,  YS_CIN,  RF_B,  '0, RF_SC);
         PC_W'(32): w = u_emit(EK_START);
         PC_W'(33): w = u_emit(EK_EXH);
         default:   w = u_emit(EK_EXH);
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/qre_modmul.sv
// ----------------------------------------------------------------------------
// qre_modmul: bit-serial modular multiplier
// Computes x*y mod p one bit of y per cycle, most significant bit first,
// with a doubling and an optional add, each followed by one reduction.
// ----------------------------------------------------------------------------
module qre_modmul #(
   parameter int MOD_WIDTH = qre_pkg::MOD_WIDTH_DEF,
   parameter int Y_WIDTH   = qre_pkg::FIELD_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 short_op,
   input  logic [MOD_WIDTH-1:0] x,
   input  logic [Y_WIDTH-1:0]   y,
   input  logic [MOD_WIDTH-1:0] modulus,
   output logic                 done,
   output logic [MOD_WIDTH-1:0] product
);
   import qre_pkg::*;

   localparam int CNT_W = $clog2(Y_WIDTH + 1);

   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] x_ff;
   logic [Y_WIDTH-1:0]   y_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [MOD_WIDTH:0]   dbl, dbl_red, sum, sum_red;

   // Invariant: acc_ff and x_ff stay below the modulus, so one subtract
   // reduces each partial value.
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum     = dbl_red + {1'b0, x_ff};
      sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
      acc_in  = y_ff[Y_WIDTH-1] ? sum_red[MOD_WIDTH-1:0] : dbl_red[MOD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CNT_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         acc_ff <= '0;
         x_ff   <= x;
         y_ff   <= short_op ? (y << (Y_WIDTH - K_W)) : y;
         cnt_ff <= short_op ? CNT_W'(K_W) : CNT_W'(Y_WIDTH);
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         y_ff   <= y_ff << 1;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/core/qre_datapath.sv
// ----------------------------------------------------------------------------
// qre_datapath: operand store and arithmetic for the residue enumerator
// Register file, counter a, done flag, modular add/subtract and the shared
// modular multiplier, all steered by the current control word.
// ----------------------------------------------------------------------------
module qre_datapath #(
   parameter int MOD_WIDTH = qre_pkg::MOD_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  qre_pkg::ctl_type                 ctl,
   input  logic                             capture,
   input  logic                             req_opcode,
   input  logic [qre_pkg::FIELD_WIDTH-1:0]  req_coef_c,
   input  logic [MOD_WIDTH-1:0]             modulus,
   input  logic [MOD_WIDTH-1:0]             coef_b,
   output qre_pkg::flags_type               flags,
   output qre_pkg::rsp_type                 result
);
   import qre_pkg::*;

   localparam int Y_WIDTH = (MOD_WIDTH > FIELD_WIDTH) ? MOD_WIDTH : FIELD_WIDTH;

   logic                   opcode_ff;
   logic [FIELD_WIDTH-1:0] coef_c_ff;
   logic [MOD_WIDTH-1:0]   a_ff, a_in;
   logic                   done_ff, done_in;
   logic [MOD_WIDTH-1:0]   rf_mem [RF_DEPTH];
   logic [MOD_WIDTH-1:0]   rd_x_ff, rd_y_ff;
   logic [MOD_WIDTH-1:0]   r3_ff, r4_ff, r5_ff;

   logic [MOD_WIDTH-1:0]   x_op;
   logic [Y_WIDTH-1:0]     y_op;
   logic [MOD_WIDTH:0]     add_sum, add_red, sub_diff, sub_red;
   logic [MOD_WIDTH-1:0]   alu_res, mul_res, wr_data;
   logic                   wr_en, mul_done;

   always_comb begin
      case (ctl.word.xs)
         XS_ONE:  x_op = MOD_WIDTH'(1);
         XS_A:    x_op = a_ff;
         default: x_op = rd_x_ff;
      endcase
      case (ctl.word.ys)
         YS_A:    y_op = Y_WIDTH'(a_ff);
         YS_CFGB: y_op = Y_WIDTH'(coef_b);
         YS_CIN:  y_op = Y_WIDTH'(coef_c_ff);
         YS_K:    y_op = Y_WIDTH'(ctl.word.kval);
         default: y_op = Y_WIDTH'(rd_y_ff);
      endcase
   end

   // Both operands of an add or subtract are already reduced.
   always_comb begin
      add_sum  = {1'b0, rd_x_ff} + {1'b0, rd_y_ff};
      add_red  = (add_sum >= {1'b0, modulus}) ? add_sum - {1'b0, modulus} : add_sum;
      sub_diff = {1'b0, rd_x_ff} - {1'b0, rd_y_ff};
      sub_red  = sub_diff[MOD_WIDTH] ? sub_diff + {1'b0, modulus} : sub_diff;
      alu_res  = (ctl.word.op == OP_ADD) ? add_red[MOD_WIDTH-1:0] : sub_red[MOD_WIDTH-1:0];
      wr_en    = ctl.mul_wb ||
                 (ctl.exec && ((ctl.word.op == OP_ADD) || (ctl.word.op == OP_SUB)));
      wr_data  = ctl.mul_wb ? mul_res : alu_res;
   end

   qre_modmul #(
      .MOD_WIDTH (MOD_WIDTH),
      .Y_WIDTH   (Y_WIDTH)
   ) u_modmul (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.mul_start),
      .short_op (ctl.word.short_mul),
      .x        (x_op),
      .y        (y_op),
      .modulus  (modulus),
      .done     (mul_done),
      .product  (mul_res)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (ctl.word.dst)
            RF_R3:   r3_ff <= wr_data;
            RF_R4:   r4_ff <= wr_data;
            RF_R5:   r5_ff <= wr_data;
            default: rf_mem[ctl.word.dst] <= wr_data;
         endcase
      end
      rd_x_ff <= rf_mem[ctl.word.rx];
      rd_y_ff <= rf_mem[ctl.word.ry];
   end

   always_comb begin
      a_in    = a_ff;
      done_in = done_ff;
      if (ctl.exec) begin
         case (ctl.word.op)
            OP_INCA: a_in = a_ff + MOD_WIDTH'(1);
            OP_EMIT: begin
               if (ctl.word.ek == EK_START) begin
                  a_in    = '0;
                  done_in = 1'b0;
               end else if (ctl.word.ek == EK_EXH) begin
                  done_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= '0;
         done_ff <= 1'b1;
      end else begin
         a_ff    <= a_in;
         done_ff <= done_in;
      end
      if (capture) begin
         opcode_ff <= req_opcode;
         coef_c_ff <= req_coef_c;
      end
   end

   always_comb begin
      flags.start_op = (opcode_ff == OPC_START);
      flags.done     = done_ff;
      flags.exhaust  = (a_ff >= modulus) || (a_ff == '0);
      flags.mul_done = mul_done;
   end

   always_comb begin
      result = '0;
      case (ctl.word.ek)
         EK_RESULT: begin
            result.residue_three = FIELD_WIDTH'(r3_ff);
            result.residue_four  = FIELD_WIDTH'(r4_ff);
            result.residue_five  = FIELD_WIDTH'(r5_ff);
            result.counter_value = FIELD_WIDTH'(a_ff);
         end
         EK_START: ;
         default: begin
            result.counter_value = FIELD_WIDTH'(a_ff);
            result.exhausted     = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/core/qre_sequencer.sv
// ----------------------------------------------------------------------------
// qre_sequencer: microcode step counter and control
// Fetches one control word per step from the program table, takes the
// conditional jumps, and waits on the multiplier and the result register.
// ----------------------------------------------------------------------------
module qre_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  qre_pkg::flags_type flags,
   input  logic               out_free,
   output qre_pkg::ctl_type   ctl,
   output logic               idle
);
   import qre_pkg::*;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_FETCH,
      SQ_EXEC,
      SQ_WAIT
   } sq_state_type;

   sq_state_type      state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   ucode_type         word;
   logic              cond_hit;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      case (word.cond)
         CD_START:   cond_hit = flags.start_op;
         CD_DONE:    cond_hit = flags.done;
         CD_EXHAUST: cond_hit = flags.exhaust;
         default:    cond_hit = 1'b0;
      endcase
   end

   // The fetch phase lets the register file read settle into its output
   // registers; jumps resolve there and need no execute phase.
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (go) begin
               state_in = SQ_FETCH;
               pc_in    = '0;
            end
         end
         SQ_FETCH: begin
            if (word.op == OP_JUMP) begin
               pc_in = cond_hit ? word.target : pc_ff + PC_W'(1);
            end else begin
               state_in = SQ_EXEC;
            end
         end
         SQ_EXEC: begin
            case (word.op)
               OP_MUL: state_in = SQ_WAIT;
               OP_EMIT: begin
                  if (out_free) begin
                     state_in = SQ_IDLE;
                  end
               end
               default: begin
                  state_in = SQ_FETCH;
                  pc_in    = pc_ff + PC_W'(1);
               end
            endcase
         end
         SQ_WAIT: begin
            if (flags.mul_done) begin
               state_in = SQ_FETCH;
               pc_in    = pc_ff + PC_W'(1);
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      ctl.word      = word;
      ctl.exec      = (state_ff == SQ_EXEC) && ((word.op != OP_EMIT) || out_free);
      ctl.mul_start = (state_ff == SQ_EXEC) && (word.op == OP_MUL);
      ctl.mul_wb    = (state_ff == SQ_WAIT) && flags.mul_done;
   end

   assign idle = (state_ff == SQ_IDLE);

endmodule

FILE: rtl/core/quintic_residue_enumerator.sv
// ----------------------------------------------------------------------------
// quintic_residue_enumerator: counter enumeration with three residues mod p
// Steps a counter a through 0..p-1 and returns 10a^3-6ba^2+3ca,
// 15a^4-8ba^3+3ca^2 and 6a^5-3ba^4+ca^3 reduced modulo p for each a.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Carries
//  req_      in         req_valid/req_ready  opcode (start or advance), coef_c
//  rsp_      out        rsp_valid/rsp_ready  three residues, counter, exhausted
//  CSR       in/out     psel/penable/pready  modulus at 0x0, coef_b at 0x4
//
// One request is worked on at a time by a microcoded sequencer; the shared
// bit-serial modular multiplier sets the pace. An advance that computes
// residues performs twelve full-width and eight 4-bit constant
// multiplications.
// Reset clears the sequencer, the counter and coef_b and sets the modulus to two;
// the enumeration reads as exhausted until the first start request.
// A new request is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register; a stalled result only
// holds the sequencer at its final step.
//
module quintic_residue_enumerator #(
   parameter int MOD_WIDTH = qre_pkg::MOD_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [qre_pkg::FIELD_WIDTH-1:0]  req_coef_c,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [qre_pkg::FIELD_WIDTH-1:0]  rsp_residue_three,
   output logic [qre_pkg::FIELD_WIDTH-1:0]  rsp_residue_four,
   output logic [qre_pkg::FIELD_WIDTH-1:0]  rsp_residue_five,
   output logic [qre_pkg::FIELD_WIDTH-1:0]  rsp_counter_value,
   output logic                             rsp_exhausted,

   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [qre_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [qre_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [qre_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import qre_pkg::*;

   logic [FIELD_WIDTH-1:0] modulus_ff;
   logic [FIELD_WIDTH-1:0] coef_b_ff;
   logic [MOD_WIDTH-1:0]   mod_trunc, mod_eff;
   logic                   csr_write;

   ctl_type                ctl;
   flags_type              flags;
   rsp_type                dp_result;
   logic                   seq_idle;
   logic                   req_take;
   logic                   out_free;
   logic                   rsp_load;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;

   // ------------------------------------------------------------------
   // Configuration registers. Only the register-select bit of the address
   // is decoded. A modulus below two behaves as two.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         coef_b_ff  <= '0;
      end else if (csr_write) begin
         case (paddr[CSR_ADDR_W-1])
            CSR_MODULUS: modulus_ff <= pwdata[FIELD_WIDTH-1:0];
            CSR_COEF_B:  coef_b_ff  <= pwdata[FIELD_WIDTH-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_ADDR_W-1])
         CSR_MODULUS: prdata = CSR_DATA_W'(modulus_ff);
         default:     prdata = CSR_DATA_W'(coef_b_ff);
      endcase
   end

   assign mod_trunc = MOD_WIDTH'(modulus_ff);
   assign mod_eff   = (mod_trunc < MOD_WIDTH'(2)) ? MOD_WIDTH'(2) : mod_trunc;

   // ------------------------------------------------------------------
   // Sequencer and datapath. The request payload is captured on accept so
   // the sender may move on at once.
   // ------------------------------------------------------------------
   assign req_ready = seq_idle;
   assign req_take  = req_valid && req_ready;

   qre_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .go       (req_take),
      .flags    (flags),
      .out_free (out_free),
      .ctl      (ctl),
      .idle     (seq_idle)
   );

   qre_datapath #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .capture    (req_take),
      .req_opcode (req_opcode),
      .req_coef_c (req_coef_c),
      .modulus    (mod_eff),
      .coef_b     (MOD_WIDTH'(coef_b_ff)),
      .flags      (flags),
      .result     (dp_result)
   );

   // ------------------------------------------------------------------
   // Output register. The final program step loads it when it is empty or
   // being emptied in the same cycle, so a stalled consumer costs no more
   // than the stall itself.
   // ------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_load     = ctl.exec && (ctl.word.op == OP_EMIT);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_ff <= dp_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_residue_three = rsp_ff.residue_three;
   assign rsp_residue_four  = rsp_ff.residue_four;
   assign rsp_residue_five  = rsp_ff.residue_five;
   assign rsp_counter_value = rsp_ff.counter_value;
   assign rsp_exhausted     = rsp_ff.exhausted;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // An accepted request always takes the sequencer out of idle in the next cycle.
   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer stayed idle after accepting a request");

   // The sequencer only becomes busy because a request was accepted.
   a_busy_needs_request : assert property (@(posedge clock) disable iff (reset)
      !req_ready && $past(req_ready) |-> $past(req_valid))
      else $error("sequencer started without an accepted request");

   // An exhausted result carries zero residues.
   a_exhausted_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |->
         (rsp_residue_three == '0) && (rsp_residue_four == '0) &&
         (rsp_residue_five == '0))
      else $error("exhausted result with nonzero residues");

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for quintic_residue_enumerator
// Drives start and advance requests and programs the modulus and coef_b
// registers over the APB-style port. Each accepted request is run through a
// behavioral copy of the enumerator kept in this file, and every response is
// compared field by field, in order, against the value worked out for it.
// A short table of directed requests comes first, then a back-pressure
// phase, then randomized enumerations with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qre_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int TOTAL_REQUESTS = 650;
   // No idling on either channel in any phase begun once this many requests have gone in.
   localparam int QUIET_FROM     = 590;
   // The receiver holds off this long once, so the block backs up its input.
   localparam int HOLD_CYCLES    = 1500;
   // Quiet cycles after the last response before a register write.
   localparam int SETTLE_CYCLES  = 8;
   // The tail wait outlasts a full advance at the default width.
   localparam int TAIL_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 1_500_000;
   localparam int PRINT_LIMIT    = 100;

   localparam logic OPC_ADVANCE = ~OPC_START;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MODULUS = {CSR_MODULUS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_COEF_B  = {CSR_COEF_B, 2'b00};

   localparam rsp_type ZERO_RSP = '0;

   typedef enum logic [1:0] {
      ROW_SET_MODULUS,
      ROW_SET_COEF_B,
      ROW_START,
      ROW_ADVANCE
   } row_kind_type;

   // One line of the directed plan. Where known is set, the response is the
   // one typed in the row; otherwise it comes from the enumerator copy.
   typedef struct {
      row_kind_type           kind;
      logic [FIELD_WIDTH-1:0] value;
      bit                     known;
      rsp_type                want;
   } plan_row_type;

   // ------------------------------------------------------------------------
   // Clock, reset and the signals that drive the block. Every input has a
   // known value from time zero.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid  = 1'b0;
   logic                   req_ready;
   logic                   req_opcode = OPC_START;
   logic [FIELD_WIDTH-1:0] req_coef_c = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [FIELD_WIDTH-1:0] rsp_residue_three;
   logic [FIELD_WIDTH-1:0] rsp_residue_four;
   logic [FIELD_WIDTH-1:0] rsp_residue_five;
   logic [FIELD_WIDTH-1:0] rsp_counter_value;
   logic                   rsp_exhausted;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   always #(CLK_PERIOD / 2) clock = ~clock;

   quintic_residue_enumerator dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_opcode,
      .req_coef_c,
      .rsp_valid,
      .rsp_ready,
      .rsp_residue_three,
      .rsp_residue_four,
      .rsp_residue_five,
      .rsp_counter_value,
      .rsp_exhausted,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready
   );

   // ------------------------------------------------------------------------
   // Behavioral copy of the enumerator: the two registers and the counter
   // state, at their reset values. It is stepped once per accepted request.
   // ------------------------------------------------------------------------
   logic [FIELD_WIDTH-1:0] cfg_modulus = MODULUS_RESET;
   logic [FIELD_WIDTH-1:0] cfg_coef_b  = '0;
   logic [FIELD_WIDTH-1:0] enum_a      = '0;
   logic [FIELD_WIDTH-1:0] enum_c      = '0;
   logic                   enum_done   = 1'b1;

   rsp_type pending_results[$];

   int error_count    = 0;
   int cycle_count    = 0;
   int requests_sent  = 0;
   int starts_sent    = 0;
   int advances_sent  = 0;
   int csr_writes     = 0;
   int residues_seen  = 0;
   int exhausted_seen = 0;

   // idle_on and hold_go are shared between the request side and the response side.
   logic idle_on   = 1'b1;
   logic hold_go   = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left  = 0;
   int   stall_left = 0;

   // Moduli of 0 and 1 behave as 2. The residues are reduced step by step, so
   // every intermediate value stays well inside 64 bits.
   function automatic rsp_type step_enumerator(input logic opcode,
                                               input logic [FIELD_WIDTH-1:0] coef_c);
      longint unsigned p, a, b, c, a2, a3, a4, a5;
      rsp_type r;
      p = (cfg_modulus < 2) ? 64'd2 : 64'(cfg_modulus);
      r = '0;
      if (opcode == OPC_START) begin
         enum_c    = FIELD_WIDTH'(64'(coef_c) % p);
         enum_a    = '0;
         enum_done = 1'b0;
         return r;
      end
      // An advance while exhausted, or before any start, changes nothing.
      if (enum_done) begin
         r.counter_value = enum_a;
         r.exhausted     = 1'b1;
         return r;
      end
      enum_a = enum_a + FIELD_WIDTH'(1);
      a      = 64'(enum_a);
      // The test is against the modulus in force now, so a modulus that
      // shrank under a running enumeration ends it at once.
      if (a >= p || a == 0) begin
         enum_done       = 1'b1;
         r.counter_value = enum_a;
         r.exhausted     = 1'b1;
         return r;
      end
      b  = 64'(cfg_coef_b) % p;
      c  = 64'(enum_c) % p;
      a2 = (a * a) % p;
      a3 = (a2 * a) % p;
      a4 = (a2 * a2) % p;
      a5 = (a4 * a) % p;
      // Each subtracted term is already below p, so adding p keeps it positive.
      r.residue_three = FIELD_WIDTH'((10 * a3 + ((3 * c) % p) * a + p
                                      - (((6 * b) % p) * a2) % p) % p);
      r.residue_four  = FIELD_WIDTH'((15 * a4 + ((3 * c) % p) * a2 + p
                                      - (((8 * b) % p) * a3) % p) % p);
      r.residue_five  = FIELD_WIDTH'((6 * a5 + c * a3 + p
                                      - (((3 * b) % p) * a4) % p) % p);
      r.counter_value = enum_a;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      // Keep the log readable when the block is badly broken.
      if (error_count <= PRINT_LIMIT)
         $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic compare_field(input string name, input logic [FIELD_WIDTH-1:0] got,
                                input logic [FIELD_WIDTH-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%h, expected 0x%h", name, got, want));
   endtask

   // Called at a response handshake; compares against the oldest expectation.
   task automatic check_result();
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("response with no request pending, counter %0d",
                                   rsp_counter_value));
         return;
      end
      want = pending_results.pop_front();
      compare_field("residue_three", rsp_residue_three, want.residue_three);
      compare_field("residue_four", rsp_residue_four, want.residue_four);
      compare_field("residue_five", rsp_residue_five, want.residue_five);
      compare_field("counter_value", rsp_counter_value, want.counter_value);
      compare_field("exhausted", FIELD_WIDTH'(rsp_exhausted), FIELD_WIDTH'(want.exhausted));
      if (want.exhausted)
         exhausted_seen++;
      else
         residues_seen++;
   endtask

   // ------------------------------------------------------------------------
   // Response side. Responses are checked on the pre-edge values at each
   // rising edge. rsp_ready drops in random bursts while idling is on, and
   // once for HOLD_CYCLES when the request side asks for back-pressure; the
   // hold is counted here, not by the request side.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result();
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Guard against a hang anywhere in the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request side helpers. A request is offered with a nonblocking update at
   // a rising edge and counts as accepted at the first later edge at which
   // req_ready was high. Unless idling pauses req_valid, the task returns
   // there and leaves it high for a following request, with no glitch.
   // ------------------------------------------------------------------------
   task automatic send_request(input logic opcode, input logic [FIELD_WIDTH-1:0] coef_c,
                               input bit known = 1'b0, input rsp_type want = '0);
      rsp_type predicted;
      req_valid  <= 1'b1;
      req_opcode <= opcode;
      req_coef_c <= coef_c;
      do @(posedge clock); while (!req_ready);
      predicted = step_enumerator(opcode, coef_c);
      pending_results.push_back(known ? want : predicted);
      requests_sent++;
      if (opcode == OPC_START)
         starts_sent++;
      else
         advances_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Lets every outstanding response come back, then a few quiet cycles.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes a register while the block is idle, reads it back, and updates
   // the enumerator copy. The read follows the write's access phase directly.
   task automatic program_register(input logic [CSR_ADDR_W-1:0] addr,
                                   input logic [FIELD_WIDTH-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      wait_until_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (readback !== CSR_DATA_W'(value))
         report_mismatch($sformatf("register at 0x%h reads 0x%h after writing 0x%h",
                                   addr, readback, value));
      if (addr == ADDR_MODULUS)
         cfg_modulus = value;
      else
         cfg_coef_b = value;
      csr_writes++;
   endtask

   // ------------------------------------------------------------------------
   // Directed plan. Rows with a typed response are the ones that can be read
   // straight off the behavior: a start always returns zeros, and an
   // exhausting advance returns only the counter and the flag.
   // ------------------------------------------------------------------------
   plan_row_type directed_plan [31] = '{
      // Advance straight out of reset: nothing started, so it reads exhausted.
      '{ROW_ADVANCE,     16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
      // A modulus of zero acts as two; an all-ones c is reduced to one.
      '{ROW_SET_MODULUS, 16'h0000, 1'b0, ZERO_RSP},
      '{ROW_START,       16'hFFFF, 1'b1, ZERO_RSP},
      '{ROW_ADVANCE,     16'hFFFF, 1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd2, 1'b1}},
      // Further advances while exhausted leave the counter where it stopped.
      '{ROW_ADVANCE,     16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd2, 1'b1}},
      // A modulus of one also acts as two; coef_b above p gets reduced.
      '{ROW_SET_MODULUS, 16'h0001, 1'b0, ZERO_RSP},
      '{ROW_SET_COEF_B,  16'hFFFF, 1'b0, ZERO_RSP},
      '{ROW_START,       16'h0001, 1'b1, ZERO_RSP},
      '{ROW_ADVANCE,     16'h5A5A, 1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd2, 1'b1}},
      // Largest modulus, with coef_b equal to it and c one below it.
      '{ROW_SET_MODULUS, 16'hFFFF, 1'b0, ZERO_RSP},
      '{ROW_START,       16'hFFFE, 1'b1, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'hA5A5, 1'b0, ZERO_RSP},
      // Largest 16-bit prime, a coef_b above it, and a c that needs reducing.
      '{ROW_SET_MODULUS, 16'd65521, 1'b0, ZERO_RSP},
      '{ROW_SET_COEF_B,  16'hFFFE, 1'b0, ZERO_RSP},
      '{ROW_START,       16'hFFFF, 1'b1, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b0, ZERO_RSP},
      // Shrinking the modulus under a running enumeration ends it at once.
      '{ROW_SET_MODULUS, 16'd3,    1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd3, 1'b1}},
      // Zero b and c leave only the pure power terms.
      '{ROW_SET_MODULUS, 16'd7,    1'b0, ZERO_RSP},
      '{ROW_SET_COEF_B,  16'h0000, 1'b0, ZERO_RSP},
      '{ROW_START,       16'h0000, 1'b1, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b0, ZERO_RSP},
      // Growing the modulus mid-run lets the enumeration carry on, and a new
      // coef_b takes effect on the next advance.
      '{ROW_SET_MODULUS, 16'd65521, 1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b0, ZERO_RSP},
      '{ROW_SET_COEF_B,  16'h8000, 1'b0, ZERO_RSP},
      '{ROW_ADVANCE,     16'h0000, 1'b0, ZERO_RSP}
   };

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed plan, one back-pressure phase, then
   // random enumeration phases until the request budget is spent.
   // ------------------------------------------------------------------------
   initial begin
      int                     roll;
      int                     kind;
      int                     eff_p;
      int                     adv_limit;
      int                     adv_count;
      logic [FIELD_WIDTH-1:0] new_value;
      logic [FIELD_WIDTH-1:0] c_val;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         case (directed_plan[i].kind)
            ROW_SET_MODULUS: program_register(ADDR_MODULUS, directed_plan[i].value);
            ROW_SET_COEF_B:  program_register(ADDR_COEF_B, directed_plan[i].value);
            ROW_START: begin
               send_request(OPC_START, directed_plan[i].value, directed_plan[i].known,
                            directed_plan[i].want);
            end
            default: begin
               send_request(OPC_ADVANCE, directed_plan[i].value, directed_plan[i].known,
                            directed_plan[i].want);
            end
         endcase
      end

      // Back-pressure: the receiver stops for a long stretch while advances
      // keep coming. One response sits in the output register, the sequencer
      // parks on the next, and req_ready has to drop until the hold ends.
      program_register(ADDR_MODULUS, 16'd65521);
      program_register(ADDR_COEF_B, 16'($urandom_range(0, 65520)));
      send_request(OPC_START, 16'($urandom_range(0, 65520)));
      hold_go <= 1'b1;
      repeat (8) send_request(OPC_ADVANCE, 16'($urandom_range(0, 65535)));

      while (requests_sent < TOTAL_REQUESTS) begin
         // Idling is switched per phase, so some stretches run flat out.
         idle_on <= (requests_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);

         // Mostly small moduli, so enumerations run all the way to the end;
         // now and then a large one, or a value that acts as two.
         if ($urandom_range(0, 19) != 0) begin
            roll = $urandom_range(0, 9);
            if (roll <= 4)
               new_value = 16'($urandom_range(2, 24));
            else if (roll <= 6)
               new_value = 16'($urandom_range(25, 300));
            else if (roll == 7)
               new_value = ($urandom_range(0, 1) != 0) ? 16'd65521 : 16'hFFFF;
            else if (roll == 8)
               new_value = 16'($urandom_range(30000, 65535));
            else if ($urandom_range(0, 2) == 0)
               new_value = 16'($urandom_range(0, 1));
            else
               new_value = 16'($urandom_range(0, 65535));
            program_register(ADDR_MODULUS, new_value);
         end
         eff_p = (cfg_modulus < 2) ? 2 : int'(cfg_modulus);

         // coef_b is usually a proper residue, sometimes any 16-bit value.
         if ($urandom_range(0, 4) < 3) begin
            if ($urandom_range(0, 3) != 0)
               new_value = 16'($urandom_range(0, eff_p - 1));
            else
               new_value = 16'($urandom_range(0, 65535));
            program_register(ADDR_COEF_B, new_value);
         end

         if ($urandom_range(0, 3) != 0)
            c_val = 16'($urandom_range(0, eff_p - 1));
         else
            c_val = 16'($urandom_range(0, 65535));

         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            // Well-formed enumeration: a start, advances up to exhaustion
            // (or a handful when p is large), then a few past the end.
            send_request(OPC_START, c_val);
            adv_limit = (eff_p <= 40) ? 64 : $urandom_range(2, 12);
            adv_count = 0;
            while (!enum_done && adv_count < adv_limit) begin
               send_request(OPC_ADVANCE, 16'($urandom_range(0, 65535)));
               adv_count++;
            end
            repeat ($urandom_range(0, 2))
               send_request(OPC_ADVANCE, 16'($urandom_range(0, 65535)));
         end else if (kind == 7) begin
            // Carry on the previous enumeration under the registers just
            // written, which may end it or let it run further.
            repeat ($urandom_range(1, 5))
               send_request(OPC_ADVANCE, 16'($urandom_range(0, 65535)));
         end else if (kind == 8) begin
            // Restart in the middle of an enumeration.
            send_request(OPC_START, c_val);
            repeat ($urandom_range(1, 3))
               send_request(OPC_ADVANCE, 16'($urandom_range(0, 65535)));
            send_request(OPC_START, 16'($urandom_range(0, 65535)));
            repeat ($urandom_range(1, 4))
               send_request(OPC_ADVANCE, 16'($urandom_range(0, 65535)));
         end else begin
            // Noise: any opcode, any c.
            repeat ($urandom_range(1, 6)) begin
               send_request(($urandom_range(0, 3) == 0) ? OPC_START : OPC_ADVANCE,
                            16'($urandom_range(0, 65535)));
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // Anything the block emits after this point has no request behind it.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: ran %0d starts and %0d advances with %0d register writes",
               starts_sent, advances_sent, csr_writes);
      $display("tb: checked %0d residue responses and %0d exhausted responses",
               residues_seen, exhausted_seen);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: %0d mismatches", error_count);
         $display("tb: errors");
      end
      $finish;
   end

endmodule
